// ----- src/bpr_pkg.sv -----
// Package: shared types and constants for the bitmap pixel row serializer.
package bpr_pkg;

    // Register indexes on the configuration port (byte address bit 2).
    localparam logic REG_ROW_WIDTH    = 1'b0;
    localparam logic REG_PIXEL_FORMAT = 1'b1;

    // Pixel formats.
    localparam logic FMT_MONO = 1'b0;
    localparam logic FMT_BGR  = 1'b1;

    localparam int          ROW_WIDTH_BITS  = 13;
    localparam logic [12:0] ROW_WIDTH_RESET = 13'd1;

    // Data byte counts carried by one command.
    localparam logic [1:0] NDATA_MONO = 2'd1;
    localparam logic [1:0] NDATA_BGR  = 2'd3;

    // One command: the bytes that one color pixel, or one packed byte of 1-bit pixels, causes.
    typedef struct packed {
        logic [7:0] data0;
        logic [7:0] data1;
        logic [7:0] data2;
        logic [1:0] ndata;
        logic [1:0] npad;
        logic       row_end;
    } cmd_t;

    // Row setup handed from the register file to the front end.
    typedef struct packed {
        logic       fmt_bgr;
        logic [1:0] pad;
        logic       clear;
    } row_cfg_t;

endpackage

// ----- src/bpr_front.sv -----
// Front end: takes pixels, tracks the column and packs bits into commands.
module bpr_front #(
    parameter int CW = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bpr_pkg::row_cfg_t cfg,
    input  logic [CW-1:0]     last_col,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_pixel_on,
    input  logic [7:0]        s_red,
    input  logic [7:0]        s_green,
    input  logic [7:0]        s_blue,
    output logic              push,
    output bpr_pkg::cmd_t     push_cmd,
    input  logic              q_ready
);

    logic [CW-1:0] column_reg, column_next;
    logic [2:0]    bit_pos_reg, bit_pos_next;
    logic [7:0]    acc_reg, acc_next;
    logic          accept;
    logic          row_end;
    logic [7:0]    acc_merged;
    logic          flush;

    assign s_ready    = q_ready;
    assign accept     = s_valid && s_ready;
    assign row_end    = (column_reg == last_col);
    assign acc_merged = acc_reg | ({7'b0, s_pixel_on} << (3'd7 - bit_pos_reg));
    assign flush      = (bit_pos_reg == 3'd7) || row_end;

    always_comb begin
        column_next        = column_reg;
        bit_pos_next       = bit_pos_reg;
        acc_next           = acc_reg;
        push               = 1'b0;
        push_cmd.data0     = acc_merged;
        push_cmd.data1     = s_green;
        push_cmd.data2     = s_red;
        push_cmd.ndata     = bpr_pkg::NDATA_MONO;
        push_cmd.npad      = row_end ? cfg.pad : 2'd0;
        push_cmd.row_end   = row_end;
        if (cfg.fmt_bgr) begin
            push_cmd.data0 = s_blue;
            push_cmd.ndata = bpr_pkg::NDATA_BGR;
        end
        if (cfg.clear) begin
            column_next  = '0;
            bit_pos_next = '0;
            acc_next     = '0;
        end else if (accept) begin
            column_next = row_end ? '0 : column_reg + 1'b1;
            if (cfg.fmt_bgr) begin
                push = 1'b1;
            end else if (flush) begin
                push         = 1'b1;
                acc_next     = '0;
                bit_pos_next = '0;
            end else begin
                acc_next     = acc_merged;
                bit_pos_next = bit_pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg  <= '0;
            bit_pos_reg <= '0;
            acc_reg     <= '0;
        end else begin
            column_reg  <= column_next;
            bit_pos_reg <= bit_pos_next;
            acc_reg     <= acc_next;
        end
    end

    // A row end always sends at least one byte.
    a_row_end_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && row_end && !cfg.clear) |-> push)
        else $error("row end without a command");

    // Color mode never leaves packing state behind.
    a_bgr_no_pack: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.fmt_bgr |-> (bit_pos_reg == 3'd0 && acc_reg == 8'd0))
        else $error("packing state left in color mode");

    // Column stays inside the configured row.
    a_column_range: assert property (@(posedge aclk) disable iff (!aresetn)
        column_reg <= last_col)
        else $error("column past row end");

endmodule

// ----- src/bpr_cmd_queue.sv -----
// Command queue: two-entry FIFO between the front and back ends.
module bpr_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bpr_pkg::cmd_t push_cmd,
    output logic          ready,
    input  logic          pop,
    output logic          head_valid,
    output bpr_pkg::cmd_t head_cmd
);

    bpr_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign ready      = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + do_push;
        rd_ptr_next = rd_ptr_reg + do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/bpr_back.sv -----
// Back end: walks each command byte by byte into the output register.
module bpr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  bpr_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_data_byte,
    output logic          m_row_done,
    output logic          m_run_last
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       row_done_reg, row_done_next;
    logic       run_last_reg, run_last_next;
    logic       slot_free;
    logic       load;
    logic [2:0] total;
    logic       last;
    logic [7:0] cur_byte;

    assign slot_free = !valid_reg || m_ready;
    assign load      = slot_free && head_valid;
    assign total     = {1'b0, head_cmd.ndata} + {1'b0, head_cmd.npad};
    assign last      = (idx_reg == total - 3'd1);
    assign pop       = load && last;

    always_comb begin
        cur_byte = 8'd0;
        if (idx_reg < {1'b0, head_cmd.ndata}) begin
            case (idx_reg)
                3'd0:    cur_byte = head_cmd.data0;
                3'd1:    cur_byte = head_cmd.data1;
                3'd2:    cur_byte = head_cmd.data2;
                default: cur_byte = 8'd0;
            endcase
        end
    end

    always_comb begin
        idx_next      = idx_reg;
        valid_next    = valid_reg;
        data_next     = data_reg;
        row_done_next = row_done_reg;
        run_last_next = run_last_reg;
        if (load) begin
            valid_next    = 1'b1;
            data_next     = cur_byte;
            row_done_next = last && head_cmd.row_end;
            run_last_next = last;
            idx_next      = last ? 3'd0 : idx_reg + 3'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg     <= data_next;
        row_done_reg <= row_done_next;
        run_last_reg <= run_last_next;
    end

    assign m_valid     = valid_reg;
    assign m_data_byte = data_reg;
    assign m_row_done  = row_done_reg;
    assign m_run_last  = run_last_reg;

    // The row's last byte is always the last byte of its command.
    a_row_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && row_done_reg) |-> run_last_reg)
        else $error("row done on a non-final byte");

    // A command in progress keeps its queue entry.
    a_mid_run_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != 3'd0) |-> head_valid)
        else $error("byte index set with empty queue");

    // No command runs past six bytes.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= 3'd5)
        else $error("byte index out of range");

endmodule

// ----- src/bmp_pixel_row_serializer.sv -----
// Top level: register file plus front end, command queue and back end.
// Path: a pixel accepted by the front end goes into a command in the queue, and the back end
// loads its bytes one by one into its output register. Throughput: one byte per cycle on
// the output while m_ready is high and the queue holds a command; a 24-bit pixel gives three
// bytes, a row end adds up to three padding bytes, and 1-bit pixels are taken one per cycle while the queue has room.
// Reset (aresetn low, synchronous): row width 1, 1-bit format, empty queue, fresh row.
module bmp_pixel_row_serializer #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_pixel_on,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    // byte output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_byte,
    output logic        m_row_done,
    output logic        m_run_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    // Raw register values, read back as written.
    logic [12:0]   row_width_reg;
    logic          pixel_format_reg;
    // Row geometry derived at write time: last column and pad counts per format.
    logic [CW-1:0] last_col_reg, last_col_next;
    logic [1:0]    pad_mono_reg, pad_mono_next;
    logic [1:0]    pad_bgr_reg, pad_bgr_next;

    logic          wr_en;
    logic          reg_sel;
    logic [31:0]   wr_width;
    logic [31:0]   row_bytes_mono;

    bpr_pkg::row_cfg_t cfg;
    logic              push;
    bpr_pkg::cmd_t     push_cmd;
    logic              q_ready;
    logic              pop;
    logic              head_valid;
    bpr_pkg::cmd_t     head_cmd;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Read back: hold the raw register contents.
    always_comb begin
        unique case (reg_sel)
            bpr_pkg::REG_ROW_WIDTH:    prdata = {19'd0, row_width_reg};
            bpr_pkg::REG_PIXEL_FORMAT: prdata = {31'd0, pixel_format_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Effective width of a new row_width value: zero counts as one, clamp to MAX_WIDTH.
    always_comb begin
        wr_width = {19'd0, pwdata[12:0]};
        if (wr_width == 32'd0) begin
            wr_width = 32'd1;
        end else if (wr_width > 32'(MAX_WIDTH)) begin
            wr_width = 32'(MAX_WIDTH);
        end
        row_bytes_mono = (wr_width + 32'd7) >> 3;
        last_col_next  = CW'(wr_width - 32'd1);
        // 3*w mod 4 mirrors w mod 4, so the color pad is just the low two bits.
        pad_bgr_next   = wr_width[1:0];
        pad_mono_next  = 2'd0 - row_bytes_mono[1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg    <= bpr_pkg::ROW_WIDTH_RESET;
            pixel_format_reg <= bpr_pkg::FMT_MONO;
            last_col_reg     <= '0;
            pad_mono_reg     <= 2'd3;
            pad_bgr_reg      <= 2'd1;
        end else if (wr_en) begin
            case (reg_sel)
                bpr_pkg::REG_ROW_WIDTH: begin
                    row_width_reg <= pwdata[12:0];
                    last_col_reg  <= last_col_next;
                    pad_mono_reg  <= pad_mono_next;
                    pad_bgr_reg   <= pad_bgr_next;
                end
                default: begin
                    pixel_format_reg <= pwdata[0];
                end
            endcase
        end
    end

    // Any register write starts a new row and drops a partial byte.
    assign cfg.fmt_bgr = (pixel_format_reg == bpr_pkg::FMT_BGR);
    assign cfg.pad     = cfg.fmt_bgr ? pad_bgr_reg : pad_mono_reg;
    assign cfg.clear   = wr_en;

    bpr_front #(
        .CW(CW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .last_col   (last_col_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel_on (s_pixel_on),
        .s_red      (s_red),
        .s_green    (s_green),
        .s_blue     (s_blue),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_ready    (q_ready)
    );

    bpr_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    bpr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_byte (m_data_byte),
        .m_row_done  (m_row_done),
        .m_run_last  (m_run_last)
    );

endmodule
